FILE: design/shell_line_tokenizer_checker_unit_defines.svh
// ----------------------------------------------------------------------------
// shell_line_tokenizer_checker_unit_defines
// Assertion macros shared by the tokenizer/checker RTL.
// ----------------------------------------------------------------------------
`ifndef SHELL_LINE_TOKENIZER_CHECKER_UNIT_DEFINES_SVH
`define SHELL_LINE_TOKENIZER_CHECKER_UNIT_DEFINES_SVH

// Checked on every clock edge outside reset.
`define SLTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define SLTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: design/sltc_pkg.sv
// ----------------------------------------------------------------------------
// sltc_pkg
// Types, codes and character constants of the shell line tokenizer/checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sltc_pkg;

  localparam int ResDepthDefault = 4;

  typedef enum logic [2:0] {
    KIND_CHAR   = 3'd0,
    KIND_WEND   = 3'd1,
    KIND_PIPE   = 3'd2,
    KIND_IN     = 3'd3,
    KIND_OUT    = 3'd4,
    KIND_APPEND = 3'd5,
    KIND_BG     = 3'd6,
    KIND_DONE   = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    LEX_WORD,
    LEX_PIPE,
    LEX_IN,
    LEX_OUT,
    LEX_APPEND,
    LEX_BG
  } tok_e;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_ESCAPE      = 4'd1;
  localparam logic [3:0] ST_QUOTE       = 4'd2;
  localparam logic [3:0] ST_EMPTY_PIPE  = 4'd3;
  localparam logic [3:0] ST_PIPE_END    = 4'd4;
  localparam logic [3:0] ST_BG_NOT_END  = 4'd5;
  localparam logic [3:0] ST_NO_PATH     = 4'd6;
  localparam logic [3:0] ST_MULTI_IN    = 4'd7;
  localparam logic [3:0] ST_MULTI_OUT   = 4'd8;
  localparam logic [3:0] ST_EMPTY_STAGE = 4'd9;
  localparam logic [3:0] ST_IN_LATER    = 4'd10;
  localparam logic [3:0] ST_OUT_NOTLAST = 4'd11;

  localparam logic [1:0] Q_NONE   = 2'd0;
  localparam logic [1:0] Q_SINGLE = 2'd1;
  localparam logic [1:0] Q_DOUBLE = 2'd2;

  localparam logic [1:0] RP_NONE   = 2'd0;
  localparam logic [1:0] RP_IN     = 2'd1;
  localparam logic [1:0] RP_OUT    = 2'd2;
  localparam logic [1:0] RP_APPEND = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_PIPE  = 8'h7C;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] word_char;
    logic [3:0] status;
    logic       last;
  } res_t;

  // Results of one accepted byte: n entries, ent[0] first.
  typedef struct packed {
    logic [1:0]       n;
    res_t [1:0]       ent;
  } push_t;

endpackage

`default_nettype wire

FILE: design/shell_line_tokenizer_checker_unit.sv
// ----------------------------------------------------------------------------
// shell_line_tokenizer_checker_unit
// Streaming shell command line tokenizer with grammar and pipeline checks.
// ----------------------------------------------------------------------------
// Takes one line byte per transfer (byte 0 ends the line) and streams out word
// characters, word ends, operator tokens and a final line-done status. A byte
// is taken whenever the result queue has room for two entries, so
// bytes go in back to back; a byte yields zero, one or two results, and the
// queue drains one result per output transfer, so a run of two-result bytes
// (such as '>' resolved by the next byte, or a word end followed by an
// operator) settles at the drain rate of one result per cycle while out_ready_i
// is high. ResDepth sets the queue depth (at least 2).
`timescale 1ns / 1ps
`default_nettype none
`include "shell_line_tokenizer_checker_unit_defines.svh"

module shell_line_tokenizer_checker_unit #(
  parameter int ResDepth = sltc_pkg::ResDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  ch_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       kind_o,
  output logic [7:0]       word_char_o,
  output logic [3:0]       status_o,
  output logic             last_o
);
  import sltc_pkg::*;

  push_t push;
  res_t  head;
  logic  accept;

  assign accept = in_valid_i && in_ready_o;

  sltc_lexer u_lexer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .ch_i     (ch_i),
    .push_o   (push)
  );

  sltc_res_fifo #(
    .Depth (ResDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .head_o  (head)
  );

  assign kind_o      = head.kind;
  assign word_char_o = head.word_char;
  assign status_o    = head.status;
  assign last_o      = head.last;

  `SLTC_ASSERT(a_stall_has_results, !in_ready_o |-> out_valid_o, "input stalled, queue empty")
  `SLTC_ASSERT(a_done_is_last, (out_valid_o && kind_o == KIND_DONE) |-> last_o, "done not last")
  `SLTC_ASSERT(a_eol_yields_result, (accept && ch_i == CH_NUL) |=> out_valid_o, "line end lost")
  `SLTC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "results visible in reset")

endmodule

`default_nettype wire

FILE: design/sltc_res_fifo.sv
// ----------------------------------------------------------------------------
// sltc_res_fifo
// Result queue: takes up to two results per cycle, drains one per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sltc_res_fifo #(
  parameter int Depth = sltc_pkg::ResDepthDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire sltc_pkg::push_t push_i,
  output logic                room_o,
  output logic                valid_o,
  input  wire logic           ready_i,
  output sltc_pkg::res_t      head_o
);
  import sltc_pkg::*;

  localparam int IdxW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  res_t             mem [Depth];
  logic [IdxW-1:0]  rptr_q, rptr_d, wptr_q, wptr_d, wptr1, wptr2;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             pop;

  function automatic logic [IdxW-1:0] wrap_inc(input logic [IdxW-1:0] p);
    return (p == IdxW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wptr1   = wrap_inc(wptr_q);
  assign wptr2   = wrap_inc(wptr1);
  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= CntW'(Depth - 2));
  assign pop     = valid_o && ready_i;
  assign head_o  = mem[rptr_q];

  always_comb begin
    cnt_d  = cnt_q + CntW'(push_i.n) - CntW'(pop);
    rptr_d = pop ? wrap_inc(rptr_q) : rptr_q;
    unique case (push_i.n)
      2'd1:    wptr_d = wptr1;
      2'd2:    wptr_d = wptr2;
      default: wptr_d = wptr_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      rptr_q <= '0;
      wptr_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      rptr_q <= rptr_d;
      wptr_q <= wptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem[wptr_q] <= push_i.ent[0];
    end
    if (push_i.n == 2'd2) begin
      mem[wptr1] <= push_i.ent[1];
    end
  end

endmodule

`default_nettype wire

FILE: design/sltc_lexer.sv
// ----------------------------------------------------------------------------
// sltc_lexer
// Per-byte tokenizer and grammar checker: line state and the results of a byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sltc_lexer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [7:0]  ch_i,
  output sltc_pkg::push_t  push_o
);
  import sltc_pkg::*;

  typedef struct packed {
    logic [1:0] quote;
    logic       esc;
    logic       in_word;
    logic       gt_pend;
    logic       any_tok;
    logic       later;
    logic       f_args;
    logic       f_in;
    logic       f_out;
    logic [1:0] redir;
    logic       bg_seen;
    logic       pipe_last;
    logic [3:0] gerr;
    logic [3:0] serr;
  } lex_t;

  lex_t          st_q, st_d, tmp;
  res_t [1:0]    ent;
  logic [1:0]    cnt;
  logic [3:0]    code;
  logic          is_space, is_op;

  function automatic res_t mk(input kind_e k, input logic [7:0] c, input logic [3:0] s);
    res_t r;
    r.kind      = k;
    r.word_char = c;
    r.status    = s;
    r.last      = 1'b0;
    return r;
  endfunction

  function automatic lex_t gram_err(input lex_t s, input logic [3:0] c);
    lex_t r;
    r = s;
    if (r.gerr == ST_OK) r.gerr = c;
    return r;
  endfunction

  // Token arrival: settle lookahead checks of the previous token, then its own.
  function automatic lex_t arrive(input lex_t s, input tok_e t);
    lex_t       r;
    logic [1:0] rp;
    r = s;
    r.any_tok   = 1'b1;
    r.pipe_last = 1'b0;
    if (r.bg_seen) begin
      r = gram_err(r, ST_BG_NOT_END);
      r.bg_seen = 1'b0;
    end
    if (r.redir != RP_NONE) begin
      rp      = r.redir;
      r.redir = RP_NONE;
      if (t != LEX_WORD) begin
        r = gram_err(r, ST_NO_PATH);
      end else if (rp == RP_IN) begin
        if (r.f_in) r = gram_err(r, ST_MULTI_IN);
        else r.f_in = 1'b1;
        return r;
      end else begin
        if (r.f_out) r = gram_err(r, ST_MULTI_OUT);
        else r.f_out = 1'b1;
        return r;
      end
    end
    case (t)
      LEX_WORD: r.f_args = 1'b1;
      LEX_PIPE: begin
        if (!r.f_args) begin
          r = gram_err(r, ST_EMPTY_PIPE);
        end else begin
          if (r.later && r.f_in) begin
            if (r.serr == ST_OK) r.serr = ST_IN_LATER;
          end else if (r.f_out) begin
            if (r.serr == ST_OK) r.serr = ST_OUT_NOTLAST;
          end
          r.f_args    = 1'b0;
          r.f_in      = 1'b0;
          r.f_out     = 1'b0;
          r.later     = 1'b1;
          r.pipe_last = 1'b1;
        end
      end
      LEX_BG:     r.bg_seen = 1'b1;
      LEX_IN:     r.redir   = RP_IN;
      LEX_OUT:    r.redir   = RP_OUT;
      LEX_APPEND: r.redir   = RP_APPEND;
      default:    r = s;
    endcase
    return r;
  endfunction

  assign is_space = (ch_i == CH_SPACE) || ((ch_i >= CH_TAB) && (ch_i <= CH_CR));
  assign is_op    = (ch_i == CH_PIPE) || (ch_i == CH_LT) || (ch_i == CH_GT) ||
                    (ch_i == CH_AMP);

  always_comb begin
    st_d = st_q;
    tmp  = st_q;
    ent  = '0;
    cnt  = 2'd0;
    code = ST_OK;
    if (ch_i == CH_NUL) begin
      if (st_q.esc) begin
        code = ST_ESCAPE;
      end else if (st_q.quote != Q_NONE) begin
        code = ST_QUOTE;
      end else begin
        if (tmp.gt_pend) begin
          tmp.gt_pend = 1'b0;
          tmp = arrive(tmp, LEX_OUT);
          ent[cnt[0]] = mk(KIND_OUT, 8'd0, ST_OK);
          cnt = cnt + 2'd1;
        end
        if (tmp.in_word) begin
          ent[cnt[0]] = mk(KIND_WEND, 8'd0, ST_OK);
          cnt = cnt + 2'd1;
        end
        if (tmp.redir != RP_NONE) tmp = gram_err(tmp, ST_NO_PATH);
        if (tmp.pipe_last) tmp = gram_err(tmp, ST_PIPE_END);
        if (tmp.gerr != ST_OK) code = tmp.gerr;
        else if (!tmp.any_tok) code = ST_OK;
        else if (tmp.serr != ST_OK) code = tmp.serr;
        else if (!tmp.f_args) code = ST_EMPTY_STAGE;
        else if (tmp.later && tmp.f_in) code = ST_IN_LATER;
        else code = ST_OK;
      end
      ent[cnt[0]] = mk(KIND_DONE, 8'd0, code);
      cnt  = cnt + 2'd1;
      st_d = '0;
    end else if (st_q.esc) begin
      st_d.esc = 1'b0;
      ent[0] = mk(KIND_CHAR, ch_i, ST_OK);
      cnt = 2'd1;
    end else if (st_q.quote == Q_SINGLE) begin
      if (ch_i == CH_SQ) begin
        st_d.quote = Q_NONE;
      end else begin
        ent[0] = mk(KIND_CHAR, ch_i, ST_OK);
        cnt = 2'd1;
      end
    end else if (st_q.quote == Q_DOUBLE) begin
      if (ch_i == CH_DQ) begin
        st_d.quote = Q_NONE;
      end else if (ch_i == CH_BSL) begin
        st_d.esc = 1'b1;
      end else begin
        ent[0] = mk(KIND_CHAR, ch_i, ST_OK);
        cnt = 2'd1;
      end
    end else begin
      // A pending '>' is resolved by this byte first.
      if (tmp.gt_pend && (ch_i == CH_GT)) begin
        tmp.gt_pend = 1'b0;
        tmp = arrive(tmp, LEX_APPEND);
        ent[0] = mk(KIND_APPEND, 8'd0, ST_OK);
        cnt = 2'd1;
      end else begin
        if (tmp.gt_pend) begin
          tmp.gt_pend = 1'b0;
          tmp = arrive(tmp, LEX_OUT);
          ent[0] = mk(KIND_OUT, 8'd0, ST_OK);
          cnt = 2'd1;
        end
        if (is_space || is_op) begin
          if (tmp.in_word) begin
            tmp.in_word = 1'b0;
            ent[cnt[0]] = mk(KIND_WEND, 8'd0, ST_OK);
            cnt = cnt + 2'd1;
          end
          if (ch_i == CH_GT) begin
            tmp.gt_pend = 1'b1;
          end else if (ch_i == CH_PIPE) begin
            tmp = arrive(tmp, LEX_PIPE);
            ent[cnt[0]] = mk(KIND_PIPE, 8'd0, ST_OK);
            cnt = cnt + 2'd1;
          end else if (ch_i == CH_LT) begin
            tmp = arrive(tmp, LEX_IN);
            ent[cnt[0]] = mk(KIND_IN, 8'd0, ST_OK);
            cnt = cnt + 2'd1;
          end else if (ch_i == CH_AMP) begin
            tmp = arrive(tmp, LEX_BG);
            ent[cnt[0]] = mk(KIND_BG, 8'd0, ST_OK);
            cnt = cnt + 2'd1;
          end
        end else begin
          if (!tmp.in_word) begin
            tmp.in_word = 1'b1;
            tmp = arrive(tmp, LEX_WORD);
          end
          if (ch_i == CH_SQ) begin
            tmp.quote = Q_SINGLE;
          end else if (ch_i == CH_DQ) begin
            tmp.quote = Q_DOUBLE;
          end else if (ch_i == CH_BSL) begin
            tmp.esc = 1'b1;
          end else begin
            ent[cnt[0]] = mk(KIND_CHAR, ch_i, ST_OK);
            cnt = cnt + 2'd1;
          end
        end
      end
      st_d = tmp;
    end
    // Flag the final result of this byte.
    if (cnt == 2'd1) ent[0].last = 1'b1;
    if (cnt == 2'd2) ent[1].last = 1'b1;
  end

  assign push_o.n   = accept_i ? cnt : 2'd0;
  assign push_o.ent = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (accept_i) begin
      st_q <= st_d;
    end
  end

endmodule

`default_nettype wire

FILE: sim/tb_shell_line_tokenizer_checker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shell_line_tokenizer_checker_unit
// Drives command lines byte by byte into the tokenizer/checker and compares
// each result transfer against a token predictor kept inside the bench.
// ----------------------------------------------------------------------------
// Stimulus runs as named tests: a short directed line set, randomly built
// lines (well-formed pipelines, broken token runs, byte noise), a long output
// stall that fills the result queue, drain pauses, and an idle-free tail.
module tb_shell_line_tokenizer_checker_unit;
  import sltc_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int FlArgs = 0;
  localparam int FlIn = 1;
  localparam int FlOut = 2;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] ch_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [2:0] kind_o;
  logic [7:0] word_char_o;
  logic [3:0] status_o;
  logic       last_o;

  shell_line_tokenizer_checker_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .ch_i        (ch_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .word_char_o (word_char_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Tokenizer state tracked by the predictor
  logic [1:0] tk_quote = Q_NONE;
  logic       tk_escape = 1'b0;
  logic       tk_in_word = 1'b0;
  logic       tk_gt_wait = 1'b0;
  logic       tk_any_tok = 1'b0;
  logic       tk_later = 1'b0;
  logic [2:0] tk_flags = 3'b000;
  logic [1:0] tk_redir = RP_NONE;
  logic       tk_amp = 1'b0;
  logic       tk_pipe_tail = 1'b0;
  logic [3:0] tk_gram_err = ST_OK;
  logic [3:0] tk_stage_err = ST_OK;

  res_t       byte_res[$];
  res_t       expected_tokens[$];
  logic [7:0] line_buf[$];

  int mismatch_cnt = 0;
  int bytes_sent = 0;
  int hold_cycles = 0;
  bit src_gaps = 1'b0;
  bit sink_gaps = 1'b0;

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function void clear_state();
    tk_quote = Q_NONE;
    tk_escape = 1'b0;
    tk_in_word = 1'b0;
    tk_gt_wait = 1'b0;
    tk_any_tok = 1'b0;
    tk_later = 1'b0;
    tk_flags = 3'b000;
    tk_redir = RP_NONE;
    tk_amp = 1'b0;
    tk_pipe_tail = 1'b0;
    tk_gram_err = ST_OK;
    tk_stage_err = ST_OK;
  endfunction

  function void emit_res(kind_e k, logic [7:0] c, logic [3:0] st);
    res_t r;
    r.kind = k;
    r.word_char = c;
    r.status = st;
    r.last = 1'b0;
    byte_res.push_back(r);
  endfunction

  function void note_grammar(logic [3:0] code);
    if (tk_gram_err == ST_OK) tk_gram_err = code;
  endfunction

  function void note_stage(logic [3:0] code);
    if (tk_stage_err == ST_OK) tk_stage_err = code;
  endfunction

  // Settle what the previous token still waited for, then book this one.
  function void token_arrives(tok_e t);
    logic [1:0] r;
    tk_any_tok = 1'b1;
    tk_pipe_tail = 1'b0;
    if (tk_amp) begin
      note_grammar(ST_BG_NOT_END);
      tk_amp = 1'b0;
    end
    if (tk_redir != RP_NONE) begin
      r = tk_redir;
      tk_redir = RP_NONE;
      if (t != LEX_WORD) begin
        note_grammar(ST_NO_PATH);
      end else if (r == RP_IN) begin
        if (tk_flags[FlIn]) note_grammar(ST_MULTI_IN);
        else tk_flags[FlIn] = 1'b1;
        return;
      end else begin
        if (tk_flags[FlOut]) note_grammar(ST_MULTI_OUT);
        else tk_flags[FlOut] = 1'b1;
        return;
      end
    end
    case (t)
      LEX_WORD: tk_flags[FlArgs] = 1'b1;
      LEX_PIPE: begin
        if (!tk_flags[FlArgs]) begin
          note_grammar(ST_EMPTY_PIPE);
        end else begin
          if (tk_later && tk_flags[FlIn]) note_stage(ST_IN_LATER);
          else if (tk_flags[FlOut]) note_stage(ST_OUT_NOTLAST);
          tk_flags = 3'b000;
          tk_later = 1'b1;
          tk_pipe_tail = 1'b1;
        end
      end
      LEX_BG:     tk_amp = 1'b1;
      LEX_IN:     tk_redir = RP_IN;
      LEX_OUT:    tk_redir = RP_OUT;
      LEX_APPEND: tk_redir = RP_APPEND;
      default: ;
    endcase
  endfunction

  function void emit_operator(tok_e t, kind_e k);
    token_arrives(t);
    emit_res(k, 8'h00, ST_OK);
  endfunction

  function void close_word();
    if (tk_in_word) begin
      emit_res(KIND_WEND, 8'h00, ST_OK);
      tk_in_word = 1'b0;
    end
  endfunction

  function void finish_line();
    logic [3:0] st;
    if (tk_escape) begin
      st = ST_ESCAPE;
    end else if (tk_quote != Q_NONE) begin
      st = ST_QUOTE;
    end else begin
      if (tk_gt_wait) begin
        tk_gt_wait = 1'b0;
        emit_operator(LEX_OUT, KIND_OUT);
      end
      close_word();
      if (tk_redir != RP_NONE) note_grammar(ST_NO_PATH);
      if (tk_pipe_tail) note_grammar(ST_PIPE_END);
      if (tk_gram_err != ST_OK) st = tk_gram_err;
      else if (!tk_any_tok) st = ST_OK;
      else if (tk_stage_err != ST_OK) st = tk_stage_err;
      else if (!tk_flags[FlArgs]) st = ST_EMPTY_STAGE;
      else if (tk_later && tk_flags[FlIn]) st = ST_IN_LATER;
      else st = ST_OK;
    end
    emit_res(KIND_DONE, 8'h00, st);
    clear_state();
  endfunction

  function void scan_byte(logic [7:0] c);
    if (tk_escape) begin
      tk_escape = 1'b0;
      emit_res(KIND_CHAR, c, ST_OK);
      return;
    end
    if (tk_quote == Q_SINGLE) begin
      if (c == CH_SQ) tk_quote = Q_NONE;
      else emit_res(KIND_CHAR, c, ST_OK);
      return;
    end
    if (tk_quote == Q_DOUBLE) begin
      if (c == CH_DQ) tk_quote = Q_NONE;
      else if (c == CH_BSL) tk_escape = 1'b1;
      else emit_res(KIND_CHAR, c, ST_OK);
      return;
    end
    // a held '>' is resolved by this byte
    if (tk_gt_wait) begin
      tk_gt_wait = 1'b0;
      if (c == CH_GT) begin
        emit_operator(LEX_APPEND, KIND_APPEND);
        return;
      end
      emit_operator(LEX_OUT, KIND_OUT);
    end
    if (is_blank(c)) begin
      close_word();
      return;
    end
    if (c == CH_PIPE || c == CH_LT || c == CH_GT || c == CH_AMP) begin
      close_word();
      if (c == CH_GT) tk_gt_wait = 1'b1;
      else if (c == CH_PIPE) emit_operator(LEX_PIPE, KIND_PIPE);
      else if (c == CH_LT) emit_operator(LEX_IN, KIND_IN);
      else emit_operator(LEX_BG, KIND_BG);
      return;
    end
    if (!tk_in_word) begin
      tk_in_word = 1'b1;
      token_arrives(LEX_WORD);
    end
    if (c == CH_SQ) tk_quote = Q_SINGLE;
    else if (c == CH_DQ) tk_quote = Q_DOUBLE;
    else if (c == CH_BSL) tk_escape = 1'b1;
    else emit_res(KIND_CHAR, c, ST_OK);
  endfunction

  function void tokenize_byte(logic [7:0] c);
    res_t r;
    byte_res.delete();
    if (c == CH_NUL) finish_line();
    else scan_byte(c);
    if (byte_res.size() > 0) begin
      r = byte_res.pop_back();
      r.last = 1'b1;
      byte_res.push_back(r);
    end
    foreach (byte_res[i]) expected_tokens.push_back(byte_res[i]);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    $display("%0t: mismatch: %0s", $realtime, what);
  endtask

  // Predict on every accepted byte, then check every result transfer.
  always @(posedge clk_i) begin : token_check
    res_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) tokenize_byte(ch_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d", kind_o));
        end else begin
          want = expected_tokens.pop_front();
          if (kind_o !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", kind_o, want.kind));
          if (word_char_o !== want.word_char)
            report_mismatch($sformatf("word_char %02h, expected %02h", word_char_o,
                                      want.word_char));
          if (status_o !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
          if (last_o !== want.last)
            report_mismatch($sformatf("last %b, expected %b", last_o, want.last));
        end
      end
    end
  end

  // Result sink: a long hold when one is requested, else random stall bursts.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (sink_gaps && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 13);
      end
    end
  end

  initial begin : watchdog
    int n;
    n = 0;
    while (n < CycleLimit) begin
      @(posedge clk_i);
      n++;
    end
    $display("tb_shell_line_tokenizer_checker_unit NOT OK");
    $finish;
  end

  task automatic send_byte(input logic [7:0] c);
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_byte(line_buf[i]);
  endtask

  // Drop valid and hold until every predicted result has been seen.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (expected_tokens.size() == 0);
  endtask

  function automatic bit is_special(logic [7:0] c);
    return is_blank(c) || c == CH_PIPE || c == CH_LT || c == CH_GT || c == CH_AMP ||
           c == CH_SQ || c == CH_DQ || c == CH_BSL || c == CH_NUL;
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    case ($urandom_range(0, 4))
      0, 1, 2: c = 8'($urandom_range(8'h61, 8'h7a));
      3:       c = 8'($urandom_range(8'h21, 8'h7e));
      default: c = any_byte();
    endcase
    while (is_special(c)) c = any_byte();
    return c;
  endfunction

  function automatic logic [7:0] op_char();
    case ($urandom_range(0, 3))
      0:       return CH_PIPE;
      1:       return CH_LT;
      2:       return CH_GT;
      default: return CH_AMP;
    endcase
  endfunction

  function automatic void add_sep(bit need);
    int n;
    n = need ? $urandom_range(1, 2) : $urandom_range(0, 2);
    repeat (n) begin
      if ($urandom_range(0, 9) < 7) line_buf.push_back(CH_SPACE);
      else line_buf.push_back(8'($urandom_range(CH_TAB, CH_CR)));
    end
  endfunction

  function automatic void add_word();
    logic [7:0] c;
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: repeat ($urandom_range(1, 3)) line_buf.push_back(plain_char());
        5: begin
          line_buf.push_back(CH_SQ);
          repeat ($urandom_range(0, 3)) begin
            c = any_byte();
            if (c == CH_SQ) c = "q";
            line_buf.push_back(c);
          end
          line_buf.push_back(CH_SQ);
        end
        6: begin
          line_buf.push_back(CH_DQ);
          repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 2) == 0) begin
              line_buf.push_back(CH_BSL);
              line_buf.push_back(any_byte());
            end else begin
              c = any_byte();
              if (c == CH_DQ || c == CH_BSL) c = "d";
              line_buf.push_back(c);
            end
          end
          line_buf.push_back(CH_DQ);
        end
        7: begin
          line_buf.push_back(CH_BSL);
          line_buf.push_back(any_byte());
        end
        8: line_buf.push_back(8'($urandom_range(128, 255)));
        default: begin
          line_buf.push_back(CH_DQ);
          line_buf.push_back(op_char());
          line_buf.push_back(CH_DQ);
        end
      endcase
    end
  endfunction

  // Pipeline of 1..3 stages with optional redirections and a trailing '&'.
  function automatic void build_good_line();
    int stages;
    line_buf.delete();
    add_sep(1'b0);
    stages = $urandom_range(1, 3);
    for (int s = 0; s < stages; s++) begin
      if (s > 0) begin
        line_buf.push_back(CH_PIPE);
        add_sep(1'b0);
      end
      repeat ($urandom_range(1, 3)) begin
        add_word();
        add_sep(1'b1);
      end
      if (s == 0 && $urandom_range(0, 3) == 0) begin
        line_buf.push_back(CH_LT);
        add_sep(1'b0);
        add_word();
        add_sep(1'b1);
      end
      if (s == stages - 1 && $urandom_range(0, 2) == 0) begin
        line_buf.push_back(CH_GT);
        if ($urandom_range(0, 1) == 0) line_buf.push_back(CH_GT);
        add_sep(1'b0);
        add_word();
        add_sep(1'b0);
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      line_buf.push_back(CH_AMP);
      add_sep(1'b0);
    end
    line_buf.push_back(CH_NUL);
  endfunction

  // Random token run, sometimes ending in an open quote or a bare escape.
  function automatic void build_broken_line();
    line_buf.delete();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 6))
        0, 1, 2: add_word();
        3: line_buf.push_back(CH_PIPE);
        4: line_buf.push_back(CH_LT);
        5: begin
          line_buf.push_back(CH_GT);
          if ($urandom_range(0, 2) == 0) line_buf.push_back(CH_GT);
        end
        default: line_buf.push_back(CH_AMP);
      endcase
      add_sep(1'b0);
    end
    case ($urandom_range(0, 7))
      0: begin
        line_buf.push_back(CH_SQ);
        line_buf.push_back(plain_char());
      end
      1: line_buf.push_back(CH_BSL);
      2: begin
        line_buf.push_back(CH_DQ);
        line_buf.push_back(plain_char());
      end
      default: ;
    endcase
    line_buf.push_back(CH_NUL);
  endfunction

  function automatic void build_noise_line();
    logic [7:0] c;
    line_buf.delete();
    repeat ($urandom_range(0, 10)) begin
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 8))
          0: c = CH_SQ;
          1: c = CH_DQ;
          2: c = CH_BSL;
          3: c = CH_PIPE;
          4: c = CH_LT;
          5: c = CH_GT;
          6: c = CH_AMP;
          7: c = CH_SPACE;
          default: c = CH_TAB;
        endcase
      end else begin
        c = any_byte();
      end
      line_buf.push_back(c);
    end
    line_buf.push_back(CH_NUL);
  endfunction

  function automatic void build_mixed_line();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) build_good_line();
    else if (r < 17) build_broken_line();
    else build_noise_line();
  endfunction

  // Empty line, every token kind, byte extremes, lexical errors, held '>'.
  task automatic test_directed();
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    send_byte(CH_NUL);
    send_text("''|");
    send_byte(8'hFF);
    send_text("<a>>b>c");
    send_byte(CH_TAB);
    send_byte(CH_AMP);
    send_byte(CH_NUL);
    send_byte(8'h01);
    send_byte(CH_BSL);
    send_byte(CH_NUL);
    send_text("\"\\\">");
    send_byte(CH_NUL);
    send_text("x>");
    send_byte(CH_NUL);
  endtask

  task automatic test_random_lines(input int target);
    int stop_at;
    stop_at = bytes_sent + target;
    while (bytes_sent < stop_at) begin
      src_gaps = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      build_mixed_line();
      send_line();
    end
  endtask

  // Hold the sink long enough that the result queue fills and input stalls.
  task automatic test_full_queue_stall();
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    hold_cycles = 300;
    repeat (3) begin
      build_good_line();
      send_line();
    end
    wait_drained();
  endtask

  task automatic test_drain_pause();
    repeat (8) begin
      src_gaps = ($urandom_range(0, 1) != 0);
      sink_gaps = ($urandom_range(0, 1) != 0);
      build_mixed_line();
      send_line();
      wait_drained();
    end
  endtask

  task automatic test_idle_free_tail(input int target);
    int stop_at;
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    stop_at = bytes_sent + target;
    while (bytes_sent < stop_at) begin
      build_mixed_line();
      send_line();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_lines(1050);
    test_full_queue_stall();
    test_drain_pause();
    test_idle_free_tail(150);
    wait_drained();
    // let any byte that makes no result finish inside the block
    repeat (16) @(posedge clk_i);
    if (expected_tokens.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_tokens.size()));
    if (mismatch_cnt == 0) begin
      $display("tb_shell_line_tokenizer_checker_unit OK");
    end else begin
      $display("tb_shell_line_tokenizer_checker_unit NOT OK");
    end
    $finish;
  end

endmodule
